FILE: hdl/cpfm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the capture period frequency meter.
// No dependencies; cpfm_dp, cpfm_ctrl, the top level and the checker import it.
package cpfm_pkg;

  localparam int unsigned CAP_W  = 16;
  localparam int unsigned FREQ_W = 24;
  localparam int unsigned TB_W   = 24;

  localparam logic [TB_W-1:0] TICK_RATE_RESET = 24'd250000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_CHECK,
    ST_FREQ_GO,
    ST_FREQ_WAIT,
    ST_EMIT
  } cpfm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic avg_go;
    logic freq_go;
    logic emit_zero;
    logic emit_freq;
  } cpfm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic div_done;
    logic avg_zero;
  } cpfm_status_t;

endpackage

FILE: hdl/cpfm_div.sv
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per clock.
// Depends on nothing; used by cpfm_dp.
module cpfm_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

  logic          run_r,  run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic [DW-1:0] quo_r,  quo_nxt;
  logic [VW-1:0] rem_r,  rem_nxt;
  logic [VW-1:0] dvs_r,  dvs_nxt;
  logic [VW:0]   shifted;
  logic [VW:0]   trial;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      // A borrow out of the trial subtraction means the divisor did not fit.
      if (!trial[VW]) begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/cpfm_dp.sv
`timescale 1ns / 1ps
// Datapath: time base register, run accumulator, average, frequency divider, results.
// Depends on cpfm_pkg and cpfm_div.
module cpfm_dp
  import cpfm_pkg::*;
#(
  parameter int unsigned CAPTURES   = 4,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cpfm_cmd_t         cmd,
  output cpfm_status_t      status,
  input  logic [CAP_W-1:0]  capture_time,
  input  logic              cfg_write,
  input  logic [TB_W-1:0]   cfg_tick_rate,
  output logic              out_valid,
  output logic [FREQ_W-1:0] out_frequency,
  output logic              out_zero_period
);

  localparam int unsigned SUM_W = TIMER_BITS + $clog2(CAPTURES);
  localparam int unsigned CNT_W = $clog2(CAPTURES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPTURES - 1);

  // The average divides the run sum by the constant number of periods. It is
  // formed as a multiplication by the rounded-up reciprocal 2^REC_SH / PERIODS,
  // which gives the exact truncated quotient for every sum below 2^SUM_W.
  localparam int unsigned PERIODS = CAPTURES - 1;
  localparam int unsigned REC_SH  = SUM_W + $clog2(PERIODS);
  localparam int unsigned REC_W   = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + REC_W;
  localparam logic [REC_W-1:0] RECIP =
    REC_W'(((64'd1 << REC_SH) + 64'(PERIODS) - 64'd1) / 64'(PERIODS));

  logic [TB_W-1:0]       tick_rate_r;
  logic [CNT_W-1:0]      count_r;
  logic [TIMER_BITS-1:0] prev_r;
  logic [SUM_W-1:0]      sum_r;
  logic [TIMER_BITS-1:0] avg_r;
  logic                  out_valid_r;
  logic [FREQ_W-1:0]     out_freq_r;
  logic                  out_zero_r;

  logic [31:0]           cap_ext;
  logic [TIMER_BITS-1:0] stamp;
  logic [TIMER_BITS-1:0] delta;
  logic [PROD_W-1:0]     avg_prod;
  logic                  div_start;
  logic                  div_done;
  logic [TB_W-1:0]       div_quot;

  // The stamp is reduced to the timer width; the subtraction wraps at that width.
  assign cap_ext = {{(32 - CAP_W){1'b0}}, capture_time};
  assign stamp   = cap_ext[TIMER_BITS-1:0];
  assign delta   = stamp - prev_r;

  assign avg_prod = PROD_W'(sum_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= TICK_RATE_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        tick_rate_r <= cfg_tick_rate;
      end
      if (cmd.take) begin
        count_r <= (count_r == CNT_LAST) ? '0 : count_r + 1'b1;
      end
      out_valid_r <= cmd.emit_zero | cmd.emit_freq;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prev_r <= stamp;
      sum_r  <= (count_r == '0) ? '0 : sum_r + SUM_W'(delta);
    end
    if (cmd.avg_go) begin
      avg_r <= avg_prod[REC_SH +: TIMER_BITS];
    end
    if (cmd.emit_zero || cmd.emit_freq) begin
      out_freq_r <= cmd.emit_zero ? '0 : div_quot[FREQ_W-1:0];
      out_zero_r <= cmd.emit_zero;
    end
  end

  assign div_start = cmd.freq_go;

  cpfm_div #(
    .DW(TB_W),
    .VW(TIMER_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tick_rate_r),
    .divisor  (avg_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign status.last     = (count_r == CNT_LAST);
  assign status.div_done = div_done;
  assign status.avg_zero = (avg_r == '0);

  assign out_valid       = out_valid_r;
  assign out_frequency   = out_freq_r;
  assign out_zero_period = out_zero_r;

endmodule

FILE: hdl/cpfm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences accumulation, average, division and the result.
// Depends on cpfm_pkg.
module cpfm_ctrl
  import cpfm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  cpfm_status_t status,
  output cpfm_cmd_t    cmd,
  output logic         busy
);

  cpfm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && status.last) state_nxt = ST_AVG_GO;
      end
      ST_AVG_GO:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = status.avg_zero ? ST_IDLE : ST_FREQ_GO;
      end
      ST_FREQ_GO:   state_nxt = ST_FREQ_WAIT;
      ST_FREQ_WAIT: begin
        if (status.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.take = start;
      end
      ST_AVG_GO:    cmd.avg_go = 1'b1;
      ST_CHECK:     cmd.emit_zero = status.avg_zero;
      ST_FREQ_GO:   cmd.freq_go = 1'b1;
      ST_FREQ_WAIT: cmd = '0;
      ST_EMIT:      cmd.emit_freq = 1'b1;
      default:      cmd = '0;
    endcase
  end

endmodule

FILE: hdl/capture_period_frequency_meter.sv
`timescale 1ns / 1ps
// Top level of the capture period frequency meter: controller plus datapath.
// Depends on cpfm_pkg, cpfm_ctrl, cpfm_dp (and through it cpfm_div).
//
// Channel  Direction  Handshake             Payload
// in       request    start high, busy low  in_capture_time[15:0]
// out      result     out_valid, 1 cycle    out_frequency[23:0], out_zero_period
// cfg      write      cfg_valid & cfg_ready cfg_tick_rate[23:0]
//
// A request that does not complete a run is taken while busy stays low.
// The request that completes a run holds busy high while the block forms the
// average by a reciprocal multiplication, tests it for zero and then runs the
// serial frequency division, which yields one of its 24 quotient bits per cycle.
// A zero average ends the computation after the test.
// The result strobe follows in the first idle cycle. Reset is synchronous and active
// low; the time base is writable only while busy is low; the receiver cannot stall.
module capture_period_frequency_meter
  import cpfm_pkg::*;
#(
  parameter int unsigned CAPTURES   = 4,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CAP_W-1:0]  in_capture_time,
  output logic              out_valid,
  output logic [FREQ_W-1:0] out_frequency,
  output logic              out_zero_period,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TB_W-1:0]   cfg_tick_rate
);

  cpfm_cmd_t    cmd;
  cpfm_status_t status;

  // The time base register is read by the divider during a computation, so a
  // write is held off until the block is idle again.
  assign cfg_ready = !busy;

  // The controller decides when a request is taken and when each step runs.
  cpfm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath accumulates the wrapped deltas of a run as requests arrive,
  // so only the previous stamp and a running sum are kept.
  cpfm_dp #(
    .CAPTURES   (CAPTURES),
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .capture_time    (in_capture_time),
    .cfg_write       (cfg_valid & cfg_ready),
    .cfg_tick_rate   (cfg_tick_rate),
    .out_valid       (out_valid),
    .out_frequency   (out_frequency),
    .out_zero_period (out_zero_period)
  );

endmodule

FILE: hdl/cpfm_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the capture period frequency meter, bound to the top level.
// Depends on cpfm_pkg for field widths.
module cpfm_chk
  import cpfm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [FREQ_W-1:0] out_frequency,
  input logic              out_zero_period
);

  // Results are single-cycle strobes and never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A zero-period result carries a zero frequency.
  a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_period) |-> (out_frequency == '0))
    else $error("zero-period result with nonzero frequency");

  // Busy only rises right after a request was taken.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // A result is shown once the block is idle again, after a busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a computation");

endmodule

bind capture_period_frequency_meter cpfm_chk u_cpfm_chk (.*);
